// ===== hdl/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types, codes and constants of the frame pacing counter.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

    // Field widths fixed by the stream and configuration formats
    localparam int NOW_W        = 48;
    localparam int FRAME_W      = 32;
    localparam int RATIO_W      = 8;
    localparam int PERIOD_W     = 20;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 20;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 80;

    // Default internal time width (range 32 to 64)
    localparam int TIME_WIDTH_DEF = 48;

    // Saturation limit of the frame count
    localparam logic [FRAME_W-1:0] FRAME_SAT = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_RATIO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 2'd2;

    // Configuration reset values
    localparam logic                RST_VSYNC_MODE  = 1'b0;
    localparam logic [RATIO_W-1:0]  RST_VSYNC_RATIO = 8'd1;
    localparam logic [PERIOD_W-1:0] RST_PERIOD      = 20'd16666;

    // Operation codes carried on the input tuser
    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture input transfer
        logic prep;    // settle deadline, start divider
        logic step;    // one divider iteration
        logic commit;  // write result, update pacing state
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_div;  // current item uses the divider
        logic out_free;  // output register can take a result
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hdl/fpc_div.sv =====
// ----------------------------------------------------------------------------
// fpc_div
// Restoring bit-serial divider, one quotient bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_div #(
    parameter int DIVIDEND_W = fpc_pkg::TIME_WIDTH_DEF,
    parameter int DIVISOR_W  = fpc_pkg::PERIOD_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_load,
    input  wire logic                  i_step,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic      [DIVIDEND_W-1:0] o_quotient,
    output logic      [DIVISOR_W-1:0]  o_remainder
);

    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
        n_rem = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        n_quo = {r_quo[DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (i_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// ===== hdl/fpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpc_ctrl
// Sequencer: accept, prepare, iterate the divider, write the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_ctrl #(
    parameter int TIME_WIDTH = fpc_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire fpc_pkg::t_dp_status i_status,
    output fpc_pkg::t_ctrl_cmd       o_cmd
);

    localparam int CNT_W = $clog2(TIME_WIDTH);

    fpc_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fpc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = fpc_pkg::ST_LOAD;
            end
            fpc_pkg::ST_LOAD: begin
                n_state = i_status.need_div ? fpc_pkg::ST_DIV : fpc_pkg::ST_FINISH;
            end
            fpc_pkg::ST_DIV: begin
                if (r_cnt == '0) n_state = fpc_pkg::ST_FINISH;
            end
            fpc_pkg::ST_FINISH: begin
                if (i_status.out_free) n_state = fpc_pkg::ST_IDLE;
            end
            default: n_state = fpc_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        n_cnt        = r_cnt;
        unique case (r_state)
            fpc_pkg::ST_IDLE: begin
                // hold off transfers while reset is asserted
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            fpc_pkg::ST_LOAD: begin
                o_cmd.prep = 1'b1;
                n_cnt      = CNT_W'(TIME_WIDTH - 1);
            end
            fpc_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - 1'b1;
            end
            fpc_pkg::ST_FINISH: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpc_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fpc_datapath.sv =====
// ----------------------------------------------------------------------------
// fpc_datapath
// Configuration, pacing state, divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_datapath #(
    parameter int TIME_WIDTH = fpc_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [fpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_op,
    input  wire logic [fpc_pkg::NOW_W-1:0]         i_now,
    input  wire fpc_pkg::t_ctrl_cmd                i_cmd,
    output fpc_pkg::t_dp_status                    o_status,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [fpc_pkg::FRAME_W-1:0]            o_frames,
    output logic [fpc_pkg::NOW_W-1:0]              o_deadline,
    output logic                                   o_sleep
);

    localparam int WIDE_W = (TIME_WIDTH > fpc_pkg::NOW_W) ? TIME_WIDTH : fpc_pkg::NOW_W;

    // Configuration
    logic                           r_vsync_mode;
    logic [fpc_pkg::RATIO_W-1:0]    r_vsync_ratio;
    logic [fpc_pkg::PERIOD_W-1:0]   r_period;

    // Pacing state
    logic                           r_started;
    logic [TIME_WIDTH-1:0]          r_deadline;
    logic [fpc_pkg::RATIO_W-1:0]    r_phase;

    // Captured item
    logic                           r_op;
    logic [TIME_WIDTH-1:0]          r_now;
    logic                           r_early;

    // Output register
    logic                           r_out_valid;
    logic [fpc_pkg::FRAME_W-1:0]    r_frames;
    logic [fpc_pkg::NOW_W-1:0]      r_dl_out;
    logic                           r_sleep;

    logic [TIME_WIDTH-1:0]          eff_dl;
    logic [TIME_WIDTH-1:0]          period_t;
    logic [fpc_pkg::PERIOD_W-1:0]   period_nz;
    logic [TIME_WIDTH-1:0]          dividend;
    logic [fpc_pkg::PERIOD_W-1:0]   divisor;
    logic [TIME_WIDTH-1:0]          quo;
    logic [fpc_pkg::PERIOD_W-1:0]   rem;
    logic                           use_one;
    logic [fpc_pkg::FRAME_W-1:0]    timed_frames;
    logic [TIME_WIDTH-1:0]          n_deadline;
    logic                           ratio_div;

    always_comb begin
        period_nz = (r_period == '0) ? fpc_pkg::PERIOD_W'(1) : r_period;
        period_t  = TIME_WIDTH'(period_nz);
        eff_dl    = r_started ? r_deadline : r_now;
        ratio_div = (r_vsync_ratio > fpc_pkg::RATIO_W'(1));

        if (r_vsync_mode) begin
            dividend = TIME_WIDTH'({1'b0, r_phase}) + TIME_WIDTH'(1);
            divisor  = fpc_pkg::PERIOD_W'(r_vsync_ratio);
        end else begin
            dividend = r_now - eff_dl;
            divisor  = period_nz;
        end

        use_one = r_early || (quo == '0);
        if (use_one) begin
            timed_frames = fpc_pkg::FRAME_W'(1);
            n_deadline   = r_deadline + period_t;
        end else begin
            timed_frames = (quo > TIME_WIDTH'(fpc_pkg::FRAME_SAT)) ? fpc_pkg::FRAME_SAT
                                                                    : fpc_pkg::FRAME_W'(quo);
            // period * quotient equals the elapsed time less the remainder
            n_deadline   = r_now - TIME_WIDTH'(rem);
        end

        o_status.need_div = (r_op == fpc_pkg::OP_ADVANCE) && (!r_vsync_mode || ratio_div);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    fpc_div #(
        .DIVIDEND_W (TIME_WIDTH),
        .DIVISOR_W  (fpc_pkg::PERIOD_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_load      (i_cmd.prep),
        .i_step      (i_cmd.step),
        .i_dividend  (dividend),
        .i_divisor   (divisor),
        .o_quotient  (quo),
        .o_remainder (rem)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsync_mode  <= fpc_pkg::RST_VSYNC_MODE;
            r_vsync_ratio <= fpc_pkg::RST_VSYNC_RATIO;
            r_period      <= fpc_pkg::RST_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fpc_pkg::CFG_VSYNC_MODE:  r_vsync_mode  <= i_cfg_data[0];
                fpc_pkg::CFG_VSYNC_RATIO: r_vsync_ratio <= i_cfg_data[fpc_pkg::RATIO_W-1:0];
                fpc_pkg::CFG_PERIOD:      r_period      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Captured item and early flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_now <= TIME_WIDTH'(WIDE_W'(i_now));
        end
        if (i_cmd.prep) begin
            r_early <= (r_now < eff_dl);
        end
    end

    // Pacing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_deadline <= '0;
            r_phase    <= '0;
        end else begin
            if (i_cmd.prep && r_op == fpc_pkg::OP_ADVANCE && !r_vsync_mode) begin
                r_deadline <= eff_dl;
                r_started  <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_op == fpc_pkg::OP_RESTART) begin
                    r_started <= 1'b0;
                end else if (r_vsync_mode) begin
                    if (ratio_div) r_phase <= rem[fpc_pkg::RATIO_W-1:0];
                end else begin
                    r_deadline <= n_deadline;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_sleep <= !r_vsync_mode;
            if (r_op == fpc_pkg::OP_RESTART) begin
                r_frames <= '0;
                r_dl_out <= '0;
            end else if (r_vsync_mode) begin
                r_frames <= ratio_div ? fpc_pkg::FRAME_W'(rem == '0) : fpc_pkg::FRAME_W'(1);
                r_dl_out <= '0;
            end else begin
                r_frames <= timed_frames;
                r_dl_out <= fpc_pkg::NOW_W'(WIDE_W'(n_deadline));
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_frames    = r_frames;
    assign o_deadline  = r_dl_out;
    assign o_sleep     = r_sleep;

endmodule

`default_nettype wire

// ===== hdl/frame_pacing_counter_top.sv =====
// ----------------------------------------------------------------------------
// frame_pacing_counter_top
// Works out how many content frames to run per display tick, by tick
// division in vsync mode or by elapsed-time pacing in timed mode.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  s_axis    in         tvalid / tready    tuser: operation; tdata: now_us
//  m_axis    out        tvalid / tready    tuser: sleep_needed;
//                                          tdata: frame_count, deadline_us
//  cfg       in         i_cfg_we only      i_cfg_idx, i_cfg_data
//
//  Timed advances and vsync advances with a ratio above one run the bit-serial
//  divider, one quotient bit per cycle, before the result is written. Restarts
//  and vsync advances with a ratio of one or less skip the divider. A new input
//  transfer is taken only once the previous item is written.
//  Reset is synchronous, active low; it clears configuration to its defaults,
//  the pacing state and the output register.
//  A stalled output holds the result; the next input transfer is still taken,
//  and its result waits in the final state until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_pacing_counter_top #(
    parameter int TIME_WIDTH = fpc_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    // Configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [fpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [fpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,

    // Input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [fpc_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [47:0] now_us
    input  wire logic                              s_axis_tuser,  // [0] operation

    // Output stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [fpc_pkg::M_TDATA_W-1:0]          m_axis_tdata,  // [31:0] frame_count,
                                                                  // [79:32] deadline_us
    output logic                                   m_axis_tuser   // [0] sleep_needed
);

    fpc_pkg::t_ctrl_cmd  cmd;
    fpc_pkg::t_dp_status status;

    logic [fpc_pkg::FRAME_W-1:0] frames;
    logic [fpc_pkg::NOW_W-1:0]   deadline;

    // Sequencer: owns the input handshake and the divider iteration count
    fpc_ctrl #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: configuration, pacing state, divider, output register
    fpc_datapath #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_axis_tuser),
        .i_now       (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_frames    (frames),
        .o_deadline  (deadline),
        .o_sleep     (m_axis_tuser)
    );

    // Pack result fields, frame count in the low bits
    assign m_axis_tdata = {deadline, frames};

endmodule

`default_nettype wire

// ===== hdl/fpc_checker.sv =====
// ----------------------------------------------------------------------------
// fpc_checker
// Port-level checks of the frame pacing counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_cfg_we,
    input wire logic [fpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input wire logic [fpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic [fpc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input wire logic                              s_axis_tuser,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [fpc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input wire logic                              m_axis_tuser
);

    // Vsync results, restarts in vsync mode among them, carry no deadline
    a_no_sleep_no_deadline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[79:32] == '0))
        else $error("deadline set on a result without sleep");

    // Vsync results give at most one frame
    a_vsync_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[31:1] == '0))
        else $error("vsync result with more than one frame");

    // In timed mode only a restart gives zero frames, and it has no deadline
    a_timed_zero_is_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser && m_axis_tdata[31:0] == '0)
            |-> (m_axis_tdata[79:32] == '0))
        else $error("timed advance gave zero frames");

    // One item at a time: no transfer in the cycle after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind frame_pacing_counter_top fpc_checker u_fpc_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_pacing_counter_top. A directed table walks the
// extremes of time, period and ratio, restarts, wrap and saturation. Random
// phases of plausible tick streams follow, under several register settings and
// with both stream sides throttled. A cycle-free pacing model predicts every
// result that the table does not give, and the results are checked in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TW        = fpc_pkg::TIME_WIDTH_DEF;
    localparam logic [63:0] TIME_MASK = (TW >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                   : ((64'd1 << TW) - 64'd1);
    localparam int          PHASES    = 12;
    localparam int          TICKS_PER = 116;
    localparam int          HOLD_OFF  = 300;
    localparam int          SETTLE    = 8;

    // One result of the block, in field order
    typedef struct packed {
        logic [fpc_pkg::FRAME_W-1:0] frames;
        logic [fpc_pkg::NOW_W-1:0]   deadline;
        logic                        sleep;
    } t_pacing;

    // One row of the directed table: a register write or a tick
    typedef struct {
        bit                             is_cfg;
        logic [fpc_pkg::CFG_IDX_W-1:0]  idx;
        logic [fpc_pkg::CFG_DATA_W-1:0] data;
        logic                           op;
        logic [fpc_pkg::NOW_W-1:0]      now;
        bit                             typed;
        t_pacing                        want;
    } t_vector;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [fpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [fpc_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [fpc_pkg::S_TDATA_W-1:0]  s_axis_tdata;   // [47:0] now_us
    logic                           s_axis_tuser;   // [0] operation
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [fpc_pkg::M_TDATA_W-1:0]  m_axis_tdata;   // [31:0] frame_count, [79:32] deadline_us
    logic                           m_axis_tuser;   // [0] sleep_needed

    // Pacing model: register copy and pacing state
    logic                         cfg_mode;
    logic [fpc_pkg::RATIO_W-1:0]  cfg_ratio;
    logic [fpc_pkg::PERIOD_W-1:0] cfg_period;
    logic                         started;
    logic [63:0]                  deadline;
    logic [fpc_pkg::RATIO_W-1:0]  phase;

    t_pacing expected_pacing[$];
    t_vector vectors[$];

    int src_pct;
    int snk_pct;
    int stall_left;
    bit hold_after_transfer;
    int n_ticks;
    int n_restarts;
    int n_results;
    int n_saturated;
    int n_writes;
    int n_faults;

    frame_pacing_counter_top #(
        .TIME_WIDTH    (TW)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Bound the run; a healthy run ends long before this
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Work out the result of one tick and advance the pacing state
    function automatic t_pacing pace_tick(input logic op,
                                          input logic [fpc_pkg::NOW_W-1:0] now);
        t_pacing     r;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] per;
        int          nxt;
        t          = {16'd0, now} & TIME_MASK;
        r.frames   = '0;
        r.deadline = '0;
        r.sleep    = ~cfg_mode;
        if (op == fpc_pkg::OP_RESTART) begin
            started = 1'b0;
            return r;
        end
        if (cfg_mode) begin
            // Divide display ticks; a ratio of zero or one passes every tick
            if (cfg_ratio <= 1) begin
                r.frames = 1;
            end else begin
                nxt      = (int'(phase) + 1) % int'(cfg_ratio);
                phase    = nxt[fpc_pkg::RATIO_W-1:0];
                r.frames = (phase == 0) ? 1 : 0;
            end
            return r;
        end
        if (!started) begin
            deadline = t;
            started  = 1'b1;
        end
        per = (cfg_period == 0) ? 64'd1 : {44'd0, cfg_period};
        if (t < deadline) begin
            n = 1;
        end else begin
            n = (t - deadline) / per;
            if (n == 0) n = 1;
        end
        deadline   = (deadline + per * n) & TIME_MASK;
        r.frames   = (n > 64'hFFFF_FFFF) ? fpc_pkg::FRAME_SAT : n[fpc_pkg::FRAME_W-1:0];
        r.deadline = deadline[fpc_pkg::NOW_W-1:0];
        return r;
    endfunction

    function automatic void vec_item(input logic op, input logic [fpc_pkg::NOW_W-1:0] now,
                                     input bit typed, input logic [fpc_pkg::FRAME_W-1:0] f,
                                     input logic [fpc_pkg::NOW_W-1:0] d, input logic s);
        t_vector v;
        v.is_cfg        = 1'b0;
        v.idx           = fpc_pkg::CFG_VSYNC_MODE;
        v.data          = '0;
        v.op            = op;
        v.now           = now;
        v.typed         = typed;
        v.want.frames   = f;
        v.want.deadline = d;
        v.want.sleep    = s;
        vectors.push_back(v);
    endfunction

    function automatic void vec_cfg(input logic [fpc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [fpc_pkg::CFG_DATA_W-1:0] data);
        t_vector v;
        v        = '{default: '0};
        v.is_cfg = 1'b1;
        v.idx    = idx;
        v.data   = data;
        vectors.push_back(v);
    endfunction

    // Write one register; called and returns on a falling edge
    task automatic write_reg(input logic [fpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fpc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            fpc_pkg::CFG_VSYNC_MODE:  cfg_mode   = data[0];
            fpc_pkg::CFG_VSYNC_RATIO: cfg_ratio  = data[fpc_pkg::RATIO_W-1:0];
            fpc_pkg::CFG_PERIOD:      cfg_period = data[fpc_pkg::PERIOD_W-1:0];
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every outstanding result, then let the block settle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (expected_pacing.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Offer one tick after a random gap and hold it until the transfer
    task automatic send_tick(input logic op, input logic [fpc_pkg::NOW_W-1:0] now,
                             input bit typed, input t_pacing want);
        t_pacing got;
        while (src_pct > 0 && $urandom_range(99) < src_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= now;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        got = pace_tick(op, now);
        expected_pacing.push_back(typed ? want : got);
        n_ticks++;
        if (op == fpc_pkg::OP_RESTART) n_restarts++;
        if (hold_after_transfer) begin
            stall_left          = HOLD_OFF;
            hold_after_transfer = 1'b0;
        end
        @(negedge i_clk);
    endtask

    // Receiver: random back-pressure, plus long hold-offs on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= snk_pct);
            end
        end
    end

    // Compare every result transfer with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_pacing want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pacing.size() == 0) begin
                $error("result with nothing expected: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                n_faults++;
            end else begin
                want = expected_pacing.pop_front();
                n_results++;
                if (want.frames == fpc_pkg::FRAME_SAT) n_saturated++;
                if (m_axis_tdata[31:0] !== want.frames) begin
                    $error("frame_count: expected %0d, got %0d",
                           want.frames, m_axis_tdata[31:0]);
                    n_faults++;
                end
                if (m_axis_tdata[79:32] !== want.deadline) begin
                    $error("deadline_us: expected %0d, got %0d",
                           want.deadline, m_axis_tdata[79:32]);
                    n_faults++;
                end
                if (m_axis_tuser !== want.sleep) begin
                    $error("sleep_needed: expected %b, got %b",
                           want.sleep, m_axis_tuser);
                    n_faults++;
                end
            end
        end
    end

    initial begin
        logic [63:0]                  wall;
        logic [63:0]                  eff;
        logic [fpc_pkg::NOW_W-1:0]    now;
        logic                         op;
        logic [fpc_pkg::RATIO_W-1:0]  ratio;
        logic [fpc_pkg::PERIOD_W-1:0] per;
        int                           r;

        // Hold every input at a known value and assert reset
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = fpc_pkg::CFG_VSYNC_MODE;
        i_cfg_data          = '0;
        s_axis_tvalid       = 1'b0;
        s_axis_tdata        = '0;
        s_axis_tuser        = fpc_pkg::OP_ADVANCE;
        src_pct             = 0;
        snk_pct             = 0;
        stall_left          = 0;
        hold_after_transfer = 1'b0;
        n_ticks             = 0;
        n_restarts          = 0;
        n_results           = 0;
        n_saturated         = 0;
        n_writes            = 0;
        n_faults            = 0;
        cfg_mode            = fpc_pkg::RST_VSYNC_MODE;
        cfg_ratio           = fpc_pkg::RST_VSYNC_RATIO;
        cfg_period          = fpc_pkg::RST_PERIOD;
        started             = 1'b0;
        deadline            = '0;
        phase               = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Timed mode at the reset period first: latch on the
        // first advance, exact multiple of the period, time before the deadline.
        vec_item(fpc_pkg::OP_ADVANCE, 48'd1000,  1, 32'd1, 48'd17666, 1'b1);
        vec_item(fpc_pkg::OP_ADVANCE, 48'd67664, 1, 32'd3, 48'd67664, 1'b1);
        vec_item(fpc_pkg::OP_ADVANCE, 48'd100,   1, 32'd1, 48'd84330, 1'b1);
        vec_item(fpc_pkg::OP_RESTART, 48'd5,     1, 32'd0, 48'd0,     1'b1);
        // Latch at the top of the time range; the deadline wraps
        vec_item(fpc_pkg::OP_ADVANCE, 48'hFFFF_FFFF_FFFF, 1, 32'd1, 48'd16665, 1'b1);
        vec_item(fpc_pkg::OP_ADVANCE, 48'hFFFF_FFFF_FFFF, 0, '0, '0, 1'b0);
        vec_item(fpc_pkg::OP_RESTART, 48'd0,     1, 32'd0, 48'd0,     1'b1);
        // Zero period counts as one; a huge elapsed time saturates the count
        vec_cfg(fpc_pkg::CFG_PERIOD, 20'd0);
        vec_item(fpc_pkg::OP_ADVANCE, 48'd0,     1, 32'd1, 48'd1,     1'b1);
        vec_item(fpc_pkg::OP_ADVANCE, 48'hFFFF_FFFF_FFFF, 1, fpc_pkg::FRAME_SAT,
                 48'hFFFF_FFFF_FFFF, 1'b1);
        vec_cfg(fpc_pkg::CFG_PERIOD, 20'd1000000);
        vec_item(fpc_pkg::OP_ADVANCE, 48'd3,       1, 32'd1, 48'd999999,  1'b1);
        vec_item(fpc_pkg::OP_ADVANCE, 48'd5999999, 1, 32'd5, 48'd5999999, 1'b1);
        vec_item(fpc_pkg::OP_ADVANCE, 48'd7999998, 0, '0, '0, 1'b0);
        vec_cfg(fpc_pkg::CFG_PERIOD, 20'hFFFFF);
        vec_item(fpc_pkg::OP_ADVANCE, 48'h8000_0000_0000, 0, '0, '0, 1'b0);
        // Vsync mode: ratio one, restart, ratio zero
        vec_cfg(fpc_pkg::CFG_VSYNC_MODE, 20'd1);
        vec_item(fpc_pkg::OP_ADVANCE, 48'h5555_5555_5555, 1, 32'd1, 48'd0, 1'b0);
        vec_item(fpc_pkg::OP_RESTART, 48'hAAAA_AAAA_AAAA, 1, 32'd0, 48'd0, 1'b0);
        vec_cfg(fpc_pkg::CFG_VSYNC_RATIO, 20'd0);
        vec_item(fpc_pkg::OP_ADVANCE, 48'd0, 1, 32'd1, 48'd0, 1'b0);
        // Ratio 255, then shrink the ratio below the running phase
        vec_cfg(fpc_pkg::CFG_VSYNC_RATIO, 20'd255);
        repeat (4) vec_item(fpc_pkg::OP_ADVANCE, 48'd77, 0, '0, '0, 1'b0);
        vec_cfg(fpc_pkg::CFG_VSYNC_RATIO, 20'd3);
        repeat (2) vec_item(fpc_pkg::OP_ADVANCE, 48'd78, 0, '0, '0, 1'b0);
        // Back to timed mode; pacing was cleared by the vsync restart
        vec_cfg(fpc_pkg::CFG_VSYNC_MODE, 20'd0);
        vec_item(fpc_pkg::OP_ADVANCE, 48'd4096, 0, '0, '0, 1'b0);

        foreach (vectors[i]) begin
            if (vectors[i].is_cfg) begin
                drain();
                write_reg(vectors[i].idx, vectors[i].data);
            end else begin
                send_tick(vectors[i].op, vectors[i].now, vectors[i].typed,
                          vectors[i].want);
            end
        end

        // Random phases: throttle both sides, the receiver harder first, then the sender, then neither
        for (int p = 0; p < PHASES; p++) begin
            drain();
            src_pct = (p < 4) ? 38 : (p < 8) ? 54 : 0;
            snk_pct = (p < 4) ? 54 : (p < 8) ? 38 : 0;

            // Pick a setting; the early phases cover the extremes
            case (p % 5)
                0:       ratio = 8'd0;
                1:       ratio = 8'd1;
                2:       ratio = 8'd2;
                3:       ratio = 8'd255;
                default: ratio = 8'($urandom_range(3, 254));
            endcase
            case (p % 6)
                0:       per = 20'd1;
                1:       per = 20'd1000000;
                2:       per = 20'd0;
                3:       per = 20'hFFFFF;
                4:       per = 20'($urandom_range(100, 50000));
                default: per = 20'($urandom_range(1, 1000000));
            endcase
            // Upper data bits beyond each register's width carry noise
            write_reg(fpc_pkg::CFG_VSYNC_MODE,  {19'($urandom), (p % 3 == 2) ? 1'b1 : 1'b0});
            write_reg(fpc_pkg::CFG_VSYNC_RATIO, {12'($urandom), ratio});
            write_reg(fpc_pkg::CFG_PERIOD,      per);

            eff  = (per == 0) ? 64'd1 : {44'd0, per};
            wall = {$urandom, $urandom} & 64'h0000_0FFF_FFFF_FFFF;
            for (int k = 0; k < TICKS_PER; k++) begin
                // Hold off the receiver while ticks keep coming, so the block backs up
                if (p == 1 && k == 50) hold_after_transfer = 1'b1;
                // Pause the sender until every result is in
                if (p == 5 && k == 60) drain();

                r  = $urandom_range(99);
                op = fpc_pkg::OP_ADVANCE;
                if (r < 5) begin
                    op  = fpc_pkg::OP_RESTART;
                    now = wall[fpc_pkg::NOW_W-1:0];
                end else if (r < 70) begin
                    // Regular ticks: a few periods on, with jitter
                    wall = wall + eff * $urandom_range(0, 3)
                                + $urandom_range(0, 32'(eff / 2));
                    now  = wall[fpc_pkg::NOW_W-1:0];
                end else if (r < 80) begin
                    now = wall[fpc_pkg::NOW_W-1:0] - 48'($urandom_range(1, 32'(eff)));
                end else if (r < 88) begin
                    wall = wall + ({32'd0, $urandom} << $urandom_range(0, 16));
                    now  = wall[fpc_pkg::NOW_W-1:0];
                end else if (r < 94) begin
                    now = 48'({$urandom, $urandom});
                end else begin
                    now  = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 32'(3 * eff)));
                    wall = {16'd0, now};
                end
                wall = wall & 64'h0000_FFFF_FFFF_FFFF;
                send_tick(op, now, 1'b0, '0);
            end
        end

        // Wait for the last results, then give the block time to misbehave
        drain();
        repeat (2 * TW + 8) @(posedge i_clk);

        $display("Covered %0d ticks (%0d restarts) over %0d register writes.",
                 n_ticks, n_restarts, n_writes);
        $display("Checked %0d results, %0d at the saturated count, %0d faults.",
                 n_results, n_saturated, n_faults);
        if (n_faults == 0 && expected_pacing.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
